// ===== src/vad_pkg.sv =====
// Package with widths, register indexes, reset values and shared types of the voice detector.
`default_nettype none

package vad_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned ENERGY_W   = 26;
  localparam int unsigned CROSS_W    = 10;
  localparam int unsigned CMAX_W     = 11;
  localparam int unsigned HANG_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 26;

  localparam int unsigned MAX_FRAME_SAMPLES = 1024;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd500;
  localparam logic [ENERGY_W-1:0] ENERGY_MIN_RST = 26'd300000;
  localparam logic [CROSS_W-1:0]  CROSS_MIN_RST = 10'd50;
  localparam logic [CMAX_W-1:0]   CROSS_MAX_RST = 11'd270;
  localparam logic [HANG_W-1:0]   HANG_FRAMES_RST = 8'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_THRESHOLD  = 3'd0,
    REG_ENERGY_MINIMUM    = 3'd1,
    REG_CROSSINGS_MINIMUM = 3'd2,
    REG_CROSSINGS_MAXIMUM = 3'd3,
    REG_HANGOVER_FRAMES   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                closes;
    logic                loud_seen;
    logic [ENERGY_W-1:0] energy;
    logic [CROSS_W-1:0]  crossings;
  } frame_sum_t;

endpackage

`default_nettype wire

// ===== src/vad_in_if.sv =====
// Stream interface that carries audio samples into the detector.
`default_nettype none

interface vad_in_if import vad_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink (input valid, input sample, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/vad_out_if.sv =====
// Stream interface that carries one frame decision out of the detector.
`default_nettype none

interface vad_out_if import vad_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                voice_frame;
  logic                speech_active;
  logic [HANG_W-1:0]   hangover_left;
  logic [ENERGY_W-1:0] frame_energy;
  logic [CROSS_W-1:0]  crossing_count;

  modport source (
    output valid, output voice_frame, output speech_active, output hangover_left,
    output frame_energy, output crossing_count, input ready
  );
  modport sink (
    input valid, input voice_frame, input speech_active, input hangover_left,
    input frame_energy, input crossing_count, output ready
  );
endinterface

`default_nettype wire

// ===== src/vad_cfg_if.sv =====
// Write interface for the configuration registers of the detector.
`default_nettype none

interface vad_cfg_if import vad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/voice_activity_detector.sv =====
// Top level of the energy and zero-crossing voice activity detector.
`default_nettype none

// The detector takes one signed 16-bit sample per transaction and can accept a new
// sample in every clock cycle. A sample first lands in an input register; from there the
// frame accumulators are updated and, on the last sample of a frame (frame_end
// set, or the MaxFrameSamples-th sample), the decision is written to the output register.
// When the output register still holds an untaken decision, the next frame end waits in
// the input register and the input stalls; other samples keep flowing. Configuration
// writes are taken in any cycle and should only be issued while no frame is in flight.
module voice_activity_detector import vad_pkg::*; #(
  parameter int unsigned MaxFrameSamples = MAX_FRAME_SAMPLES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vad_in_if.sink    in_i,
  vad_out_if.source out_o,
  vad_cfg_if.sink   cfg_i
);

  logic [SAMPLE_W-1:0] threshold_q;
  logic [ENERGY_W-1:0] energy_min_q;
  logic [CROSS_W-1:0]  cross_min_q;
  logic [CMAX_W-1:0]   cross_max_q;
  logic [HANG_W-1:0]   hang_frames_q;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_last_q;

  logic                out_valid_q;
  logic                voice_q;
  logic [ENERGY_W-1:0] energy_q;
  logic [CROSS_W-1:0]  cross_q;
  logic [HANG_W-1:0]   hang_q, hang_d;

  frame_sum_t          frame;
  logic                advance;
  logic                emit;
  logic                voice;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      energy_min_q <= ENERGY_MIN_RST;
      cross_min_q <= CROSS_MIN_RST;
      cross_max_q <= CROSS_MAX_RST;
      hang_frames_q <= HANG_FRAMES_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SAMPLE_THRESHOLD:  threshold_q <= cfg_i.data[SAMPLE_W-1:0];
        REG_ENERGY_MINIMUM:    energy_min_q <= cfg_i.data[ENERGY_W-1:0];
        REG_CROSSINGS_MINIMUM: cross_min_q <= cfg_i.data[CROSS_W-1:0];
        REG_CROSSINGS_MAXIMUM: cross_max_q <= cfg_i.data[CMAX_W-1:0];
        REG_HANGOVER_FRAMES:   hang_frames_q <= cfg_i.data[HANG_W-1:0];
        default: ;
      endcase
    end
  end

  vad_frame #(
    .MaxFrameSamples(MaxFrameSamples)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .sample_i   (s1_sample_q),
    .frame_end_i(s1_last_q),
    .threshold_i(threshold_q),
    .frame_o    (frame)
  );

  always_comb begin
    advance = s1_valid_q && (!frame.closes || !out_valid_q || out_o.ready);
    emit = advance && frame.closes;
    in_i.ready = !s1_valid_q || advance;
    voice = frame.loud_seen && (frame.energy > energy_min_q) &&
            (frame.crossings > cross_min_q) && ({1'b0, frame.crossings} < cross_max_q);
    if (voice) begin
      hang_d = hang_frames_q;
    end else if (hang_q != '0) begin
      hang_d = hang_q - 1'b1;
    end else begin
      hang_d = hang_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      hang_q <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        hang_q <= hang_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_sample_q <= in_i.sample;
      s1_last_q <= in_i.frame_end;
    end
    if (emit) begin
      voice_q <= voice;
      energy_q <= frame.energy;
      cross_q <= frame.crossings;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.voice_frame = voice_q;
  assign out_o.speech_active = hang_q != '0;
  assign out_o.hangover_left = hang_q;
  assign out_o.frame_energy = energy_q;
  assign out_o.crossing_count = cross_q;

endmodule

`default_nettype wire

// ===== src/vad_frame.sv =====
// Per-frame accumulation of loud-sample energy, zero crossings and frame length.
`default_nettype none

module vad_frame import vad_pkg::*; #(
  parameter int unsigned MaxFrameSamples = MAX_FRAME_SAMPLES
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                frame_end_i,
  input  wire logic [SAMPLE_W-1:0] threshold_i,
  output frame_sum_t               frame_o
);

  localparam int unsigned CntW = $clog2(MaxFrameSamples);

  logic                loud_q, loud_d;
  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [CROSS_W-1:0]  cross_q, cross_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic [MAG_W-1:0]    mag;
  logic                loud;
  logic                cross_hit;
  logic [ENERGY_W:0]   energy_sum;
  logic                closes;

  always_comb begin
    mag = sample_i[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - {1'b0, sample_i} : {1'b0, sample_i};
    loud = mag >= {1'b0, threshold_i};
    cross_hit = loud && (prev_q != '0) && (prev_q[SAMPLE_W-1] != sample_i[SAMPLE_W-1]);
    energy_sum = {1'b0, energy_q} + (ENERGY_W+1)'(mag);
    closes = frame_end_i || (cnt_q == CntW'(MaxFrameSamples - 1));

    frame_o.closes = closes;
    frame_o.loud_seen = loud_q || loud;
    frame_o.crossings = (cross_hit && cross_q != '1) ? cross_q + 1'b1 : cross_q;
    if (!loud) begin
      frame_o.energy = energy_q;
    end else if (energy_sum[ENERGY_W]) begin
      frame_o.energy = '1;
    end else begin
      frame_o.energy = energy_sum[ENERGY_W-1:0];
    end

    loud_d = loud_q;
    prev_d = prev_q;
    energy_d = energy_q;
    cross_d = cross_q;
    cnt_d = cnt_q;
    if (step_i) begin
      if (closes) begin
        loud_d = 1'b0;
        prev_d = '0;
        energy_d = '0;
        cross_d = '0;
        cnt_d = '0;
      end else begin
        loud_d = frame_o.loud_seen;
        prev_d = loud ? sample_i : '0;
        energy_d = frame_o.energy;
        cross_d = frame_o.crossings;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loud_q <= 1'b0;
      prev_q <= '0;
      energy_q <= '0;
      cross_q <= '0;
      cnt_q <= '0;
    end else begin
      loud_q <= loud_d;
      prev_q <= prev_d;
      energy_q <= energy_d;
      cross_q <= cross_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_voice_activity_detector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the voice activity detector with random handshake pacing.
module tb_voice_activity_detector;
  import vad_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam logic [ENERGY_W-1:0] EnergyCeiling = '1;
  localparam logic [CROSS_W-1:0] CrossCeiling = '1;
  localparam int unsigned RandomItems = 200;

  typedef struct packed {
    logic                voice_frame;
    logic                speech_active;
    logic [HANG_W-1:0]   hangover_left;
    logic [ENERGY_W-1:0] frame_energy;
    logic [CROSS_W-1:0]  crossing_count;
  } decision_t;

  typedef enum int {TONE, QUIET, EXTREME, NOISE} shape_e;

  class vad_scoreboard;
    logic [SAMPLE_W-1:0] threshold;
    logic [ENERGY_W-1:0] energy_min;
    logic [CROSS_W-1:0]  cross_min;
    logic [CMAX_W-1:0]   cross_max;
    logic [HANG_W-1:0]   hang_frames;
    bit                  loud_seen;
    logic [SAMPLE_W-1:0] prev_loud;
    logic [ENERGY_W:0]   energy;
    logic [CROSS_W-1:0]  crossings;
    logic [HANG_W-1:0]   hang_count;
    int unsigned         frame_len;
    decision_t           pending_q[$];
    int unsigned         errors;
    int unsigned         frames;
    int unsigned         voice_frames;
    int unsigned         samples;

    function new();
      threshold   = THRESHOLD_RST;
      energy_min  = ENERGY_MIN_RST;
      cross_min   = CROSS_MIN_RST;
      cross_max   = CROSS_MAX_RST;
      hang_frames = HANG_FRAMES_RST;
      hang_count  = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      loud_seen = 1'b0;
      prev_loud = '0;
      energy    = '0;
      crossings = '0;
      frame_len = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SAMPLE_THRESHOLD:  threshold   = data[SAMPLE_W-1:0];
        REG_ENERGY_MINIMUM:    energy_min  = data[ENERGY_W-1:0];
        REG_CROSSINGS_MINIMUM: cross_min   = data[CROSS_W-1:0];
        REG_CROSSINGS_MAXIMUM: cross_max   = data[CMAX_W-1:0];
        REG_HANGOVER_FRAMES:   hang_frames = data[HANG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic last);
      logic [MAG_W-1:0] mag;
      bit               voice;
      decision_t        d;
      samples++;
      mag = s[SAMPLE_W-1] ? ((MAG_W'(1) << SAMPLE_W) - {1'b0, s}) : {1'b0, s};
      if (mag < {1'b0, threshold}) begin
        prev_loud = '0;
      end else begin
        if (prev_loud != '0 && prev_loud[SAMPLE_W-1] != s[SAMPLE_W-1] &&
            crossings != CrossCeiling) begin
          crossings++;
        end
        energy = energy + mag;
        if (energy > EnergyCeiling) begin
          energy = EnergyCeiling;
        end
        prev_loud = s;
        loud_seen = 1'b1;
      end
      frame_len++;
      if (!(last || frame_len >= MAX_FRAME_SAMPLES)) begin
        return;
      end
      voice = loud_seen && energy > energy_min && crossings > cross_min &&
              {1'b0, crossings} < cross_max;
      if (voice) begin
        hang_count = hang_frames;
      end else if (hang_count != '0) begin
        hang_count--;
      end
      d.voice_frame    = voice;
      d.speech_active  = hang_count != '0;
      d.hangover_left  = hang_count;
      d.frame_energy   = energy[ENERGY_W-1:0];
      d.crossing_count = crossings;
      pending_q.push_back(d);
      clear_frame();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check(decision_t got);
      decision_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("decision %p arrived with no frame pending", got));
        return;
      end
      want = pending_q.pop_front();
      frames++;
      if (got.voice_frame === 1'b1) begin
        voice_frames++;
      end
      if (got.voice_frame !== want.voice_frame) begin
        report($sformatf("frame %0d voice_frame %b, expected %b", frames,
                         got.voice_frame, want.voice_frame));
      end
      if (got.speech_active !== want.speech_active) begin
        report($sformatf("frame %0d speech_active %b, expected %b", frames,
                         got.speech_active, want.speech_active));
      end
      if (got.hangover_left !== want.hangover_left) begin
        report($sformatf("frame %0d hangover_left %0d, expected %0d", frames,
                         got.hangover_left, want.hangover_left));
      end
      if (got.frame_energy !== want.frame_energy) begin
        report($sformatf("frame %0d frame_energy %0d, expected %0d", frames,
                         got.frame_energy, want.frame_energy));
      end
      if (got.crossing_count !== want.crossing_count) begin
        report($sformatf("frame %0d crossing_count %0d, expected %0d", frames,
                         got.crossing_count, want.crossing_count));
      end
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  bit            send_idle;
  bit            take_idle;
  int unsigned   cycles;
  int unsigned   settings;
  vad_scoreboard board = new();

  vad_in_if  in_if ();
  vad_out_if out_if ();
  vad_cfg_if cfg_if ();

  voice_activity_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      board.note_sample(in_if.sample, in_if.frame_end);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check(decision_t'({out_if.voice_frame, out_if.speech_active, out_if.hangover_left,
                               out_if.frame_energy, out_if.crossing_count}));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d decisions pending.", cycles,
               board.pending_q.size());
      $display("tb_voice_activity_detector failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(bit enabled);
    return enabled ? $urandom_range(0, 7) : 0;
  endfunction

  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(take_idle);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    int unsigned gap;
    gap = draw_wait(send_idle);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample    <= s;
    in_if.frame_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    board.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] th, input logic [CFG_DATA_W-1:0] emin,
                              input logic [CFG_DATA_W-1:0] cmin,
                              input logic [CFG_DATA_W-1:0] cmax,
                              input logic [CFG_DATA_W-1:0] hang, input bit stray);
    logic [CFG_IDX_W-1:0] bogus;
    write_reg(REG_SAMPLE_THRESHOLD, th);
    write_reg(REG_ENERGY_MINIMUM, emin);
    write_reg(REG_CROSSINGS_MINIMUM, cmin);
    write_reg(REG_CROSSINGS_MAXIMUM, cmax);
    write_reg(REG_HANGOVER_FRAMES, hang);
    if (stray) begin
      bogus = CFG_IDX_W'($urandom_range(int'(REG_HANGOVER_FRAMES) + 1, (1 << CFG_IDX_W) - 1));
      write_reg(bogus, CFG_DATA_W'($urandom));
    end
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] dirty(logic [CFG_DATA_W-1:0] v, int unsigned w);
    if ($urandom_range(0, 3) == 0) begin
      return v | (CFG_DATA_W'($urandom) << w);
    end
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_sample(shape_e shape, int unsigned idx);
    int t;
    int m;
    bit neg;
    t = int'(board.threshold);
    case (shape)
      TONE: begin
        m   = $urandom_range(0, (t > 16000) ? 32767 : 2 * t + 64);
        neg = idx[0] ^ ($urandom_range(0, 7) == 0);
        if (neg && $urandom_range(0, 15) == 0) begin
          m = 32768;
        end
        return SAMPLE_W'(neg ? -m : m);
      end
      QUIET: begin
        m = $urandom_range(0, (t > 0) ? t - 1 : 0);
        return SAMPLE_W'($urandom_range(0, 1) ? -m : m);
      end
      EXTREME: begin
        case ($urandom_range(0, 7))
          0: return SAMPLE_W'(-32768);
          1: return SAMPLE_W'(32767);
          2: return '0;
          3: return '1;
          4: return SAMPLE_W'(1);
          5: return SAMPLE_W'(t);
          6: return SAMPLE_W'(t - 1);
          default: return SAMPLE_W'(-t);
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int unsigned len, input shape_e shape);
    logic last;
    for (int unsigned i = 0; i < len; i++) begin
      last = (i == len - 1) || (shape == NOISE && $urandom_range(0, 9) == 0);
      push_sample(next_sample(shape, i), last);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] th;
    logic [CFG_DATA_W-1:0] emin;
    logic [CFG_DATA_W-1:0] cmin;
    logic [CFG_DATA_W-1:0] cmax;
    logic [CFG_DATA_W-1:0] hang;
    int unsigned           start_samples;
    int unsigned           phase_end;
    int unsigned           len;
    int unsigned           pick;
    shape_e                shape;

    rst_ni = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.sample    <= '0;
    in_if.frame_end <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: most negative sample, threshold edges, quiet sample clears the memory,
    // and a frame with no loud sample.
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(SAMPLE_W'(-499), 1'b0);
    push_sample(SAMPLE_W'(-500), 1'b0);
    push_sample(SAMPLE_W'(500), 1'b1);
    push_sample(SAMPLE_W'(100), 1'b1);
    drain();

    // A loud zero acts as no previous sample; longest hangover.
    program_regs(0, 0, 0, 1024, 255, 1'b1);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h0000, 1'b1);
    drain();

    // Only the most negative sample is loud, and the crossing window is empty.
    program_regs(32768, 33554432, 5, 6, 0, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b1);
    drain();

    // Voice with zero hangover, then energy equal to the minimum.
    program_regs(1, 10, 0, 2, 0, 1'b0);
    push_sample(SAMPLE_W'(1000), 1'b0);
    push_sample(SAMPLE_W'(-1000), 1'b1);
    push_sample(SAMPLE_W'(5), 1'b0);
    push_sample(SAMPLE_W'(-5), 1'b1);
    drain();

    // A frame without an end flag is closed by the length bound, with the most crossings.
    program_regs(0, 33554175, 1022, 1024, 3, 1'b0);
    send_idle = 1'b0;
    for (int unsigned i = 0; i < MAX_FRAME_SAMPLES; i++) begin
      push_sample(i[0] ? 16'h7FFF : 16'h8000, 1'b0);
    end
    push_sample(SAMPLE_W'(5), 1'b0);
    push_sample(SAMPLE_W'(-5), 1'b1);
    drain();

    start_samples = board.samples;
    while (board.samples - start_samples < RandomItems) begin
      case ($urandom_range(0, 7))
        0:       th = 0;
        1:       th = 32768;
        2:       th = CFG_DATA_W'($urandom_range(0, 32768));
        default: th = CFG_DATA_W'($urandom_range(1, 2500));
      endcase
      if ($urandom_range(0, 7) == 0) begin
        emin = CFG_DATA_W'($urandom_range(0, 33554432));
      end else begin
        emin = CFG_DATA_W'(th * $urandom_range(0, 20) + $urandom_range(0, 500));
      end
      cmin = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) :
                                                        $urandom_range(0, 10));
      if ($urandom_range(0, 7) == 0) begin
        cmax = CFG_DATA_W'($urandom_range(0, 1024));
      end else begin
        cmax = CFG_DATA_W'(cmin + $urandom_range(0, 30));
        cmax = (cmax > 1024) ? CFG_DATA_W'(1024) : cmax;
      end
      case ($urandom_range(0, 7))
        0:       hang = 255;
        1:       hang = CFG_DATA_W'($urandom_range(0, 255));
        default: hang = CFG_DATA_W'($urandom_range(0, 6));
      endcase
      program_regs(dirty(th, SAMPLE_W), emin, dirty(cmin, CROSS_W), dirty(cmax, CMAX_W),
                   dirty(hang, HANG_W), $urandom_range(0, 2) == 0);
      pick      = $urandom_range(0, 3);
      send_idle = pick != 0;
      take_idle = pick != 1;
      phase_end = board.samples + $urandom_range(80, 140);
      while (board.samples < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          len = $urandom_range(1, 24);
        end else if (pick < 19) begin
          len = $urandom_range(25, 60);
        end else begin
          len = $urandom_range(61, 200);
        end
        pick = $urandom_range(0, 9);
        shape = (pick < 6) ? TONE : (pick == 6) ? QUIET : (pick == 7) ? EXTREME : NOISE;
        send_frame(len, shape);
        if ($urandom_range(0, 11) == 0) begin
          drain();
        end
      end
      drain();
    end

    $display("Checked %0d frame decisions (%0d voice) from %0d samples.", board.frames,
             board.voice_frames, board.samples);
    $display("Register settings used: %0d, including both threshold and hangover extremes.",
             settings);
    if (board.errors == 0) begin
      $display("tb_voice_activity_detector passed");
    end else begin
      $display("tb_voice_activity_detector failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/vad_pkg.sv
src/vad_in_if.sv
src/vad_out_if.sv
src/vad_cfg_if.sv
src/vad_frame.sv
src/voice_activity_detector.sv
dv/tb_voice_activity_detector.sv
